/* hw/rtl/line_rasterizer_core_macros.svh */
// assertion shorthands used by the rasterizer walker
`ifndef LINE_RASTERIZER_CORE_MACROS_SVH
`define LINE_RASTERIZER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define LRC_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("line rasterizer check failed");

// next-cycle implication, checked out of reset
`define LRC_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("line rasterizer check failed");

`endif

/* hw/rtl/lr_pkg.sv */
`timescale 1ns / 1ps

package lr_pkg;

   localparam int TILE_SIZE      = 64;
   localparam int COORD_W        = $clog2(TILE_SIZE);
   localparam int DEC_W          = COORD_W + 2;
   localparam int CMD_FIFO_DEPTH = 2;

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } seg_req_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      logic      last_pixel;
   } pixel_rsp_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type maj_len;
      coord_type min_len;
      logic      x_dir_neg;
      logic      y_dir_neg;
      logic      major_is_y;
   } seg_cmd_type;

   typedef enum logic {
      WALK_IDLE,
      WALK_DRAW
   } walk_state_type;

   function automatic coord_type step_coord(coord_type c, logic neg);
      return neg ? (c - coord_type'(1)) : (c + coord_type'(1));
   endfunction

endpackage

/* hw/rtl/lr_front.sv */
`timescale 1ns / 1ps

module lr_front (
   input  logic                req_valid,
   output logic                req_ready,
   input  lr_pkg::seg_req_type req_data,
   output logic                push_valid,
   input  logic                push_ready,
   output lr_pkg::seg_cmd_type push_cmd
);
   import lr_pkg::*;

   logic      x_neg;
   logic      y_neg;
   coord_type abs_dx;
   coord_type abs_dy;
   logic      major_y;
   coord_type maj;

   always_comb begin
      x_neg   = req_data.end_x < req_data.start_x;
      y_neg   = req_data.end_y < req_data.start_y;
      abs_dx  = x_neg ? (req_data.start_x - req_data.end_x) : (req_data.end_x - req_data.start_x);
      abs_dy  = y_neg ? (req_data.start_y - req_data.end_y) : (req_data.end_y - req_data.start_y);
      major_y = (abs_dx == '0) || (abs_dy > abs_dx);
      maj     = major_y ? abs_dy : abs_dx;

      push_cmd.start_x    = req_data.start_x;
      push_cmd.start_y    = req_data.start_y;
      push_cmd.maj_len    = maj;
      push_cmd.min_len    = major_y ? abs_dx : abs_dy;
      push_cmd.x_dir_neg  = x_neg;
      push_cmd.y_dir_neg  = y_neg;
      push_cmd.major_is_y = major_y;
   end

   // zero-length segments are accepted and dropped here
   assign req_ready  = push_ready;
   assign push_valid = req_valid && (maj != '0);

endmodule

/* hw/rtl/lr_cmd_fifo.sv */
`timescale 1ns / 1ps

module lr_cmd_fifo #(
   parameter int DEPTH = lr_pkg::CMD_FIFO_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  lr_pkg::seg_cmd_type push_cmd,
   output logic                pop_valid,
   input  logic                pop_ready,
   output lr_pkg::seg_cmd_type pop_cmd
);
   import lr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   seg_cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hw/rtl/lr_walker.sv */
`timescale 1ns / 1ps
`include "line_rasterizer_core_macros.svh"

module lr_walker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  lr_pkg::seg_cmd_type   pop_cmd,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lr_pkg::pixel_rsp_type rsp_data
);
   import lr_pkg::*;

   walk_state_type          state_ff, state_in;
   coord_type               cur_x_ff, cur_x_in;
   coord_type               cur_y_ff, cur_y_in;
   logic signed [DEC_W-1:0] dec_ff, dec_in;
   logic signed [DEC_W-1:0] dec_sum;
   coord_type               steps_ff, steps_in;
   coord_type               maj_ff, maj_in;
   coord_type               mnr_ff, mnr_in;
   logic                    x_neg_ff, x_neg_in;
   logic                    y_neg_ff, y_neg_in;
   logic                    major_y_ff, major_y_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   pixel_rsp_type           rsp_data_ff, rsp_data_in;
   logic                    slot_free;
   logic                    emit;
   logic                    last;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last      = steps_ff == coord_type'(1);
   assign dec_sum   = dec_ff + $signed({1'b0, mnr_ff, 1'b0});

   always_comb begin
      state_in     = state_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      dec_in       = dec_ff;
      steps_in     = steps_ff;
      maj_in       = maj_ff;
      mnr_in       = mnr_ff;
      x_neg_in     = x_neg_ff;
      y_neg_in     = y_neg_ff;
      major_y_in   = major_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pop_ready    = 1'b0;
      emit         = 1'b0;
      case (state_ff)
         WALK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cur_x_in   = pop_cmd.start_x;
               cur_y_in   = pop_cmd.start_y;
               steps_in   = pop_cmd.maj_len;
               maj_in     = pop_cmd.maj_len;
               mnr_in     = pop_cmd.min_len;
               x_neg_in   = pop_cmd.x_dir_neg;
               y_neg_in   = pop_cmd.y_dir_neg;
               major_y_in = pop_cmd.major_is_y;
               dec_in     = DEC_W'(0) - $signed({2'b00, pop_cmd.maj_len});
               state_in   = WALK_DRAW;
            end
         end
         WALK_DRAW: begin
            if (slot_free) begin
               emit                   = 1'b1;
               rsp_valid_in           = 1'b1;
               rsp_data_in.pixel_x    = cur_x_ff;
               rsp_data_in.pixel_y    = cur_y_ff;
               rsp_data_in.last_pixel = last;
               steps_in               = steps_ff - coord_type'(1);
               if (last) begin
                  state_in = WALK_IDLE;
               end else begin
                  // major step, then minor step when the line passes the midpoint
                  dec_in = dec_sum;
                  if (major_y_ff) begin
                     cur_y_in = step_coord(cur_y_ff, y_neg_ff);
                  end else begin
                     cur_x_in = step_coord(cur_x_ff, x_neg_ff);
                  end
                  if (dec_sum > 0) begin
                     dec_in = dec_sum - $signed({1'b0, maj_ff, 1'b0});
                     if (major_y_ff) begin
                        cur_x_in = step_coord(cur_x_ff, x_neg_ff);
                     end else begin
                        cur_y_in = step_coord(cur_y_ff, y_neg_ff);
                     end
                  end
               end
            end
         end
         default: begin
            state_in = WALK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= WALK_IDLE;
         rsp_valid_ff <= 1'b0;
         steps_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         steps_ff     <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      dec_ff      <= dec_in;
      maj_ff      <= maj_in;
      mnr_ff      <= mnr_in;
      x_neg_ff    <= x_neg_in;
      y_neg_ff    <= y_neg_in;
      major_y_ff  <= major_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `LRC_ASSERT_IMP(a_draw_has_steps, clock, reset, state_ff == WALK_DRAW, steps_ff != '0)
   `LRC_ASSERT_IMP(a_dec_not_positive, clock, reset, state_ff == WALK_DRAW, dec_ff <= 0)
   `LRC_ASSERT_NXT(a_last_ends_segment, clock, reset, emit && last, state_ff == WALK_IDLE)
   `LRC_ASSERT_NXT(a_load_starts_draw, clock, reset, pop_valid && pop_ready,
                   state_ff == WALK_DRAW && rsp_valid_ff == $past(rsp_valid_ff && !rsp_ready))

endmodule

/* hw/rtl/line_rasterizer_core.sv */
`timescale 1ns / 1ps

// Midpoint line rasterizer for one 64x64 tile. Each request beat carries a segment; the core
// returns one response beat per pixel, starting at the start point and stopping before the end
// point, so a segment gives max(|dx|,|dy|) beats, the final one marked by last_pixel, and a
// zero-length segment gives none. The front end classifies a segment in the cycle it is taken
// and queues it; the pixel walker then loads it from the queue and emits one pixel per cycle
// while the response side keeps up; it takes the next segment only after the last pixel of
// the current one is emitted. A request passes through the command queue and the walker's
// registers before its first pixel appears in the response register. The command queue holds
// CMD_FIFO_DEPTH segments, so requests keep being taken while an earlier segment is still drawing.
module line_rasterizer_core #(
   parameter int CMD_FIFO_DEPTH = lr_pkg::CMD_FIFO_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lr_pkg::seg_req_type   req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lr_pkg::pixel_rsp_type rsp_data
);
   import lr_pkg::*;

   logic        push_valid;
   logic        push_ready;
   seg_cmd_type push_cmd;
   logic        pop_valid;
   logic        pop_ready;
   seg_cmd_type pop_cmd;

   lr_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   lr_cmd_fifo #(
      .DEPTH (CMD_FIFO_DEPTH)
   ) u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   lr_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* verif/tb_line_rasterizer_core.sv */
`timescale 1ns / 1ps

module tb_line_rasterizer_core;
   import lr_pkg::*;

   localparam int RANDOM_SEGMENTS = 357;
   localparam int QUIET_TAIL      = 60;
   localparam int PAUSE_AT        = 150;
   localparam int TAIL_CYCLES     = 150;
   localparam int WATCHDOG_CYCLES = 2000;

   class pixel_scoreboard;
      pixel_rsp_type pending_pixels[$];
      int errors;
      int segments;
      int zero_len;
      int y_major;
      int ties;
      int pixels;

      function new();
         errors   = 0;
         segments = 0;
         zero_len = 0;
         y_major  = 0;
         ties     = 0;
         pixels   = 0;
      endfunction

      task report(string msg);
         errors++;
         $display("ERROR: %s", msg);
      endtask

      // midpoint walk of one segment, end point excluded
      task note_segment(seg_req_type s);
         coord_type     px;
         coord_type     py;
         coord_type     dxa;
         coord_type     dya;
         logic          xneg;
         logic          yneg;
         logic          along_y;
         int            maj_len;
         int            min_len;
         int            err;
         pixel_rsp_type p;
         xneg    = s.end_x < s.start_x;
         yneg    = s.end_y < s.start_y;
         dxa     = xneg ? s.start_x - s.end_x : s.end_x - s.start_x;
         dya     = yneg ? s.start_y - s.end_y : s.end_y - s.start_y;
         along_y = (dxa == 0) || (dya > dxa);
         maj_len = along_y ? int'(dya) : int'(dxa);
         min_len = along_y ? int'(dxa) : int'(dya);
         px      = s.start_x;
         py      = s.start_y;
         err     = -maj_len;
         segments++;
         if (maj_len == 0) begin
            zero_len++;
         end
         if (along_y && maj_len != 0) begin
            y_major++;
         end
         for (int k = maj_len; k > 0; k--) begin
            p.pixel_x    = px;
            p.pixel_y    = py;
            p.last_pixel = (k == 1);
            pending_pixels.push_back(p);
            if (k == 1) begin
               break;
            end
            err = err + 2 * min_len;
            if (err == 0) begin
               ties++;
            end
            if (along_y) begin
               py = yneg ? py - coord_type'(1) : py + coord_type'(1);
               if (err > 0) begin
                  px  = xneg ? px - coord_type'(1) : px + coord_type'(1);
                  err = err - 2 * maj_len;
               end
            end else begin
               px = xneg ? px - coord_type'(1) : px + coord_type'(1);
               if (err > 0) begin
                  py  = yneg ? py - coord_type'(1) : py + coord_type'(1);
                  err = err - 2 * maj_len;
               end
            end
         end
      endtask

      task check_pixel(pixel_rsp_type got);
         pixel_rsp_type want;
         pixels++;
         if (pending_pixels.size() == 0) begin
            report($sformatf("unexpected pixel beat x=%0d y=%0d last=%0b",
                             got.pixel_x, got.pixel_y, got.last_pixel));
         end else begin
            want = pending_pixels.pop_front();
            if (got.pixel_x !== want.pixel_x) begin
               report($sformatf("pixel %0d: pixel_x got %0d want %0d",
                                pixels, got.pixel_x, want.pixel_x));
            end
            if (got.pixel_y !== want.pixel_y) begin
               report($sformatf("pixel %0d: pixel_y got %0d want %0d",
                                pixels, got.pixel_y, want.pixel_y));
            end
            if (got.last_pixel !== want.last_pixel) begin
               report($sformatf("pixel %0d: last_pixel got %0b want %0b",
                                pixels, got.last_pixel, want.last_pixel));
            end
         end
      endtask
   endclass

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   seg_req_type   req_data;
   logic          rsp_valid;
   logic          rsp_ready;
   pixel_rsp_type rsp_data;

   pixel_scoreboard sb;
   logic            quiet;
   int              gap_pct;
   int              stall_pct;
   int              stall_left;
   int              ready_cycles;
   int              stalled_cycles;

   line_rasterizer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int pick_pct();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 10;
         2: return 30;
         default: return 60;
      endcase
   endfunction

   function automatic seg_req_type make_segment(int sx, int sy, int ex, int ey);
      seg_req_type s;
      s.start_x = coord_type'(sx);
      s.start_y = coord_type'(sy);
      s.end_x   = coord_type'(ex);
      s.end_y   = coord_type'(ey);
      return s;
   endfunction

   function automatic coord_type nearby(coord_type c);
      int v;
      v = int'(c) + int'($urandom_range(0, 6)) - 3;
      if (v < 0) begin
         v = 0;
      end
      if (v > TILE_SIZE - 1) begin
         v = TILE_SIZE - 1;
      end
      return coord_type'(v);
   endfunction

   function automatic seg_req_type random_segment();
      seg_req_type s;
      int          len;
      logic        xneg;
      logic        yneg;
      s.start_x = coord_type'($urandom_range(0, 63));
      s.start_y = coord_type'($urandom_range(0, 63));
      s.end_x   = coord_type'($urandom_range(0, 63));
      s.end_y   = coord_type'($urandom_range(0, 63));
      case ($urandom_range(0, 9))
         5, 6: begin
            s.end_x = nearby(s.start_x);
            s.end_y = nearby(s.start_y);
         end
         7: begin
            if ($urandom_range(0, 1)) begin
               s.end_x = s.start_x;
            end else begin
               s.end_y = s.start_y;
            end
         end
         8: begin
            len       = $urandom_range(0, 63);
            xneg      = 1'($urandom_range(0, 1));
            yneg      = 1'($urandom_range(0, 1));
            s.start_x = coord_type'(xneg ? $urandom_range(len, 63)
                                         : $urandom_range(0, 63 - len));
            s.start_y = coord_type'(yneg ? $urandom_range(len, 63)
                                         : $urandom_range(0, 63 - len));
            s.end_x   = coord_type'(xneg ? int'(s.start_x) - len : int'(s.start_x) + len);
            s.end_y   = coord_type'(yneg ? int'(s.start_y) - len : int'(s.start_y) + len);
         end
         9: begin
            s.end_x = s.start_x;
            s.end_y = s.start_y;
         end
         default: begin
         end
      endcase
      return s;
   endfunction

   task drive_segment(seg_req_type s);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 10);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      sb.note_segment(s);
   endtask

   task drain_pixels();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
   endtask

   task run_directed();
      drive_segment(make_segment(0, 0, 0, 0));
      drive_segment(make_segment(63, 63, 63, 63));
      drive_segment(make_segment(0, 0, 63, 63));
      drive_segment(make_segment(63, 63, 0, 0));
      drive_segment(make_segment(0, 63, 63, 0));
      drive_segment(make_segment(0, 0, 63, 0));
      drive_segment(make_segment(63, 5, 0, 5));
      drive_segment(make_segment(7, 0, 7, 63));
      drive_segment(make_segment(7, 63, 7, 0));
      // all eight octants around the tile center
      drive_segment(make_segment(32, 32, 52, 39));
      drive_segment(make_segment(32, 32, 39, 52));
      drive_segment(make_segment(32, 32, 25, 52));
      drive_segment(make_segment(32, 32, 12, 39));
      drive_segment(make_segment(32, 32, 12, 25));
      drive_segment(make_segment(32, 32, 25, 12));
      drive_segment(make_segment(32, 32, 39, 12));
      drive_segment(make_segment(32, 32, 52, 25));
      // midpoint ties, shallow and steep, then segments with no tie
      drive_segment(make_segment(10, 10, 14, 12));
      drive_segment(make_segment(10, 10, 11, 12));
      drive_segment(make_segment(5, 5, 6, 5));
      drive_segment(make_segment(0, 0, 63, 1));
      drive_segment(make_segment(63, 0, 62, 63));
      drive_segment(make_segment(0, 62, 63, 0));
   endtask

   // response side backpressure
   initial begin
      rsp_ready    = 1'b0;
      stall_left   = 0;
      stall_pct    = 25;
      ready_cycles = 0;
      forever begin
         @(negedge clock);
         ready_cycles++;
         if (ready_cycles % 256 == 0) begin
            stall_pct = pick_pct();
         end
         if (quiet) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            rsp_ready  <= 1'b0;
            stall_left = $urandom_range(1, 10) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // pixel checking and watchdog
   always @(posedge clock) begin
      if (reset) begin
         stalled_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sb.check_pixel(rsp_data);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stalled_cycles <= 0;
         end else begin
            stalled_cycles <= stalled_cycles + 1;
         end
         if (stalled_cycles >= WATCHDOG_CYCLES) begin
            $display("watchdog: no beat for %0d cycles, %0d pixels outstanding",
                     stalled_cycles, sb.pending_pixels.size());
            $display("line_rasterizer_core: mismatch");
            $finish;
         end
      end
   end

   initial begin
      sb        = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      quiet     = 1'b0;
      gap_pct   = 30;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      drain_pixels();

      for (int i = 0; i < RANDOM_SEGMENTS; i++) begin
         if (i % 40 == 0) begin
            gap_pct = pick_pct();
         end
         if (i == RANDOM_SEGMENTS - QUIET_TAIL) begin
            quiet = 1'b1;
         end
         if (i == PAUSE_AT) begin
            drain_pixels();
         end
         drive_segment(random_segment());
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("segments drawn: %0d (%0d zero-length, %0d y-major), midpoint ties seen: %0d",
               sb.segments, sb.zero_len, sb.y_major, sb.ties);
      $display("pixel beats checked: %0d, errors: %0d", sb.pixels, sb.errors);
      if (sb.errors == 0) begin
         $display("line_rasterizer_core: match");
      end else begin
         $display("line_rasterizer_core: mismatch");
      end
      $finish;
   end

endmodule
